// File: rtl/qsdd_pkg.sv
// ----------------------------------------------------------------------------
// qsdd_pkg
// Shared types, constants and decision helpers for the 32-point cross-QAM
// slicer with differential quadrant decoding.
// ----------------------------------------------------------------------------
package qsdd_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned LabelW  = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [LabelW-1:0]         label_t;
  typedef logic [1:0]                quad_t;
  typedef logic signed [SampleW:0]   ext_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1
  } cfg_idx_e;

  // Decision thresholds as one group
  typedef struct packed {
    logic [ThrW-1:0] inner;
    logic [ThrW-1:0] outer;
  } thr_t;

  localparam logic [ThrW-1:0] InnerReset = 15'd3277;
  localparam logic [ThrW-1:0] OuterReset = 15'd6554;

  // Labels of the two outer I columns, indexed by the four-way Q bin
  localparam label_t LeftCol[4]  = '{5'd24, 5'd25, 5'd19, 5'd18};
  localparam label_t RightCol[4] = '{5'd10, 5'd11, 5'd1, 5'd0};

  // Labels of inner I columns 1..4, indexed by the six-way Q bin
  localparam label_t InnerCols[4][6] = '{
    '{5'd26, 5'd28, 5'd29, 5'd22, 5'd20, 5'd16},
    '{5'd27, 5'd30, 5'd31, 5'd23, 5'd21, 5'd17},
    '{5'd9,  5'd13, 5'd15, 5'd7,  5'd6,  5'd3 },
    '{5'd8,  5'd12, 5'd14, 5'd5,  5'd4,  5'd2 }
  };

  // Gray pair (b4,b3) to quadrant index, and back
  localparam quad_t GrayToQuad[4] = '{2'd0, 2'd3, 2'd1, 2'd2};
  localparam quad_t QuadToGray[4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  // Six-way bin: the first comparison that holds wins, ties fall low.
  function automatic logic [2:0] bin6(ext_t x, ext_t t1, ext_t t2);
    logic [2:0] b;
    if (x <= -t2) begin
      b = 3'd0;
    end else if (x <= -t1) begin
      b = 3'd1;
    end else if (x <= ext_t'(0)) begin
      b = 3'd2;
    end else if (x <= t1) begin
      b = 3'd3;
    end else if (x <= t2) begin
      b = 3'd4;
    end else begin
      b = 3'd5;
    end
    return b;
  endfunction

  // Four-way bin used in the merged outer columns.
  function automatic logic [1:0] bin4(ext_t x, ext_t t1);
    logic [1:0] b;
    if (x <= -t1) begin
      b = 2'd0;
    end else if (x <= ext_t'(0)) begin
      b = 2'd1;
    end else if (x <= t1) begin
      b = 2'd2;
    end else begin
      b = 2'd3;
    end
    return b;
  endfunction

endpackage

// File: rtl/qsdd_slicer.sv
// ----------------------------------------------------------------------------
// qsdd_slicer
// Hard-decision slicer: maps one I/Q sample to its 5-bit cross-QAM label.
// ----------------------------------------------------------------------------
module qsdd_slicer import qsdd_pkg::*; (
  input  logic [SampleW-1:0] i_sample_i,
  input  logic [SampleW-1:0] q_sample_i,
  input  thr_t               thr_i,
  output label_t             label_o
);

  ext_t       i_ext;
  ext_t       q_ext;
  ext_t       t1;
  ext_t       t2;
  logic [2:0] i_bin;
  logic [2:0] q_bin6;
  logic [1:0] q_bin4;
  logic [2:0] col_off;

  // Sign-extend samples and zero-extend thresholds to a common signed width.
  assign i_ext = ext_t'(signed'({i_sample_i[SampleW-1], i_sample_i}));
  assign q_ext = ext_t'(signed'({q_sample_i[SampleW-1], q_sample_i}));
  assign t1    = ext_t'(signed'({2'b00, thr_i.inner}));
  assign t2    = ext_t'(signed'({2'b00, thr_i.outer}));

  // Axis decisions.
  assign i_bin  = bin6(i_ext, t1, t2);
  assign q_bin6 = bin6(q_ext, t1, t2);
  assign q_bin4 = bin4(q_ext, t1);
  assign col_off = i_bin - 3'd1;

  // Outer columns use the merged four-way Q decision.
  always_comb begin
    unique case (i_bin) inside
      3'd0:    label_o = LeftCol[q_bin4];
      3'd5:    label_o = RightCol[q_bin4];
      3'd1, 3'd2, 3'd3, 3'd4: begin
        label_o = (q_bin6 <= 3'd5) ? InnerCols[col_off[1:0]][q_bin6] : '0;
      end
      default: label_o = '0;
    endcase
  end

endmodule

// File: rtl/qam32_slicer_differential_decoder.sv
// ----------------------------------------------------------------------------
// qam32_slicer_differential_decoder
// 32-point cross-QAM hard-decision slicer with differential quadrant decoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one signed Q2.13 I/Q sample
//   per transaction. Output channel (out_valid_o/out_ready_i) returns one
//   transaction per input: the decoded data symbol and the raw slicer label.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes the inner (index 0)
//   or outer (index 1) threshold; other indexes are ignored. It is always
//   ready and should be used only while the block is idle.
// Timing:
//   A sample is held in an input register, sliced and decoded from there,
//   and lands in the result register, which drives out_valid_o. Throughput
//   is one transaction per cycle while out_ready_i is high, set by the
//   single register-to-register decision path.
// Reset:
//   Thresholds return to 0.4 and 0.8, the previous quadrant to zero, and
//   both stages empty. The previous quadrant is kept across bursts.
// Stall:
//   While out_ready_i is low the result holds; one more sample is accepted
//   into the input register, then in_ready_o drops.
// ----------------------------------------------------------------------------
module qam32_slicer_differential_decoder import qsdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ThrW-1:0]    cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] in_phase_i,
  input  logic [SampleW-1:0] quadrature_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LabelW-1:0]  data_symbol_o,
  output logic [LabelW-1:0]  sliced_label_o
);

  thr_t               thr_q;
  logic               s1_valid_q;
  logic [SampleW-1:0] i_q;
  logic [SampleW-1:0] q_q;
  logic               out_valid_q;
  label_t             data_q;
  label_t             label_q;
  quad_t              prev_quad_q;
  quad_t              prev_quad_d;

  logic               advance;
  logic               s1_fire;
  label_t             label;
  quad_t              quad;
  quad_t              diff;
  label_t             data_sym;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.inner <= InnerReset;
      thr_q.outer <= OuterReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_INNER) begin
        thr_q.inner <= cfg_data_i;
      end else if (cfg_index_i == CFG_OUTER) begin
        thr_q.outer <= cfg_data_i;
      end
    end
  end

  // Pipeline flow control: the result register frees when taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      i_q <= in_phase_i;
      q_q <= quadrature_i;
    end
  end

  // Slicer.
  qsdd_slicer u_slicer (
    .i_sample_i (i_q),
    .q_sample_i (q_q),
    .thr_i      (thr_q),
    .label_o    (label)
  );

  // Differential quadrant decoding against the previous symbol.
  always_comb begin
    quad        = GrayToQuad[label[4:3]];
    diff        = quad - prev_quad_q;
    data_sym    = {QuadToGray[diff], label[2:0]};
    prev_quad_d = s1_fire ? quad : prev_quad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_quad_q <= '0;
    end else begin
      prev_quad_q <= prev_quad_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      data_q  <= data_sym;
      label_q <= label;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_symbol_o  = data_q;
  assign sliced_label_o = label_q;

`ifndef ASSERT_OFF
  // The stored quadrant moves only when a symbol enters the result register.
  a_prev_quad_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(prev_quad_q))
    else $error("previous quadrant changed without a decoded symbol");

  // A taken result with nothing behind it leaves the output empty.
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");

  // Input backpressure only when both stages are full and the output stalls.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // The three low label bits pass through differential decoding untouched.
  a_low_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_symbol_o[2:0] == sliced_label_o[2:0]))
    else $error("low data bits differ from the label");
`endif

endmodule
